// ===== design/vrp_pkg.sv =====
package vrp_pkg;

  // Local video memory sizes
  localparam int NAME_RAM_DEPTH = 4096;
  localparam int NAME_AW        = $clog2(NAME_RAM_DEPTH);
  localparam int PALETTE_DEPTH  = 32;
  localparam int PAL_AW         = $clog2(PALETTE_DEPTH);

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register numbers
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SPADDR = 3'd3;
  localparam logic [2:0] REG_SPDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // Video address map limits
  localparam logic [15:0] PATTERN_LAST = 16'h1FFF;
  localparam logic [15:0] NAME_LAST    = 16'h3EFF;
  localparam logic [15:0] PALETTE_LAST = 16'h3FFF;

  // Power-up palette contents, listed from entry 31 down to entry 0
  localparam logic [PALETTE_DEPTH-1:0][7:0] PAL_DEFAULT = {
    8'h15, 8'h37, 8'h01, 8'h0D, 8'h37, 8'h30, 8'h06, 8'h0D,
    8'h24, 8'h17, 8'h30, 8'h0D, 8'h16, 8'h35, 8'h02, 8'h0D,
    8'h24, 8'h3C, 8'h30, 8'h0D, 8'h07, 8'h35, 8'h30, 8'h0D,
    8'h06, 8'h27, 8'h30, 8'h0D, 8'h07, 8'h3C, 8'h15, 8'h0D
  };

  typedef struct packed {
    logic               we;
    logic               re;
    logic [NAME_AW-1:0] addr;
    logic [7:0]         wdata;
  } name_req_t;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] idx;
    logic [7:0]        wdata;
  } pal_req_t;

  // Backdrop entries of the sprite half mirror the background half
  function automatic logic [PAL_AW-1:0] pal_index(input logic [15:0] a);
    logic [PAL_AW-1:0] i;
    i = a[PAL_AW-1:0];
    if (i[4] && (i[1:0] == 2'b00)) begin
      i[4] = 1'b0;
    end
    return i;
  endfunction

endpackage

// ===== design/vrp_name_ram.sv =====
module vrp_name_ram (
  input  logic               clk,
  input  vrp_pkg::name_req_t req,
  output logic [7:0]         q
);
  import vrp_pkg::*;

  logic [7:0] mem [NAME_RAM_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Registered read port; hold data between reads
  always_ff @(posedge clk) begin
    if (req.re) begin
      q <= mem[req.addr];
    end
  end

endmodule

// ===== design/vrp_palette.sv =====
module vrp_palette (
  input  logic              clk,
  input  logic              rst,
  input  vrp_pkg::pal_req_t req,
  output logic [7:0]        rd_data
);
  import vrp_pkg::*;

  logic [7:0] entries [PALETTE_DEPTH];

  // Load default palette on reset, otherwise store addressed entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        entries[i] <= PAL_DEFAULT[i];
      end
    end else if (req.we) begin
      entries[req.idx] <= req.wdata;
    end
  end

  assign rd_data = entries[req.idx];

endmodule

// ===== design/video_register_port_with_vram.sv =====
// Video register port with local name and palette memory.
// Input channel: one CPU access per beat (opcode, reg_select, write_data,
// plus chr_byte, the cartridge pattern byte at the last chr_address shown).
// Output channel: one result beat per input beat (read_data, chr_address,
// chr_read), in order.
// Latency: the result is valid the cycle after the input beat is taken.
// Throughput: one access per cycle; a new beat is taken while the previous
// result waits, as long as the output register is free or being emptied.
// The name RAM read is registered; its byte lands in the read buffer path in the
// following cycle, which the next data-port read picks up without a bubble.
// When the receiver stalls, the result is held and in_stall rises so the
// sender holds its next beat.
// Reset clears the register file, address latch, read buffer and out_valid and
// reloads the default palette; name RAM contents stay undefined until written.
module video_register_port_with_vram (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [2:0]  reg_select,
  input  logic [7:0]  write_data,
  input  logic [7:0]  chr_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [12:0] chr_address,
  output logic        chr_read
);
  import vrp_pkg::*;

  typedef enum logic [1:0] {
    RGN_PATTERN,
    RGN_NAME,
    RGN_PALETTE,
    RGN_NONE
  } region_t;

  logic        accept;
  logic        is_write;
  logic [7:0]  control_reg;
  logic [7:0]  mask_reg;
  logic [7:0]  status_reg;
  logic [7:0]  sprite_addr_reg;
  logic [7:0]  sprite_data_reg;
  logic [7:0]  scroll_reg;
  logic [15:0] video_address;
  logic [15:0] video_address_next;
  logic        high_byte_next;
  logic [7:0]  read_buffer;
  logic        buf_pending;
  logic [7:0]  buf_now;
  logic        buf_load;
  logic [7:0]  buf_val;
  logic        set_pending;
  logic [7:0]  rd;
  logic        took_chr;
  logic [7:0]  ram_q;
  logic [7:0]  pal_q;
  region_t     region;
  name_req_t   name_req;
  pal_req_t    pal_req;

  // Handshake: output register frees up or drains this cycle
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign is_write = (opcode == OP_WRITE);

  // Buffer byte may still be arriving from name RAM
  assign buf_now = buf_pending ? ram_q : read_buffer;

  // Decode video address region
  always_comb begin
    if (video_address <= PATTERN_LAST) begin
      region = RGN_PATTERN;
    end else if (video_address <= NAME_LAST) begin
      region = RGN_NAME;
    end else if (video_address <= PALETTE_LAST) begin
      region = RGN_PALETTE;
    end else begin
      region = RGN_NONE;
    end
  end

  // Decode access
  always_comb begin
    rd             = 8'h00;
    took_chr       = 1'b0;
    buf_load       = 1'b0;
    buf_val        = 8'h00;
    set_pending    = 1'b0;
    name_req.we    = 1'b0;
    name_req.re    = 1'b0;
    name_req.addr  = video_address[NAME_AW-1:0];
    name_req.wdata = write_data;
    pal_req.we     = 1'b0;
    pal_req.idx    = pal_index(video_address);
    pal_req.wdata  = write_data;
    if (accept && is_write) begin
      if (reg_select == REG_DATA) begin
        name_req.we = (region == RGN_NAME);
        pal_req.we  = (region == RGN_PALETTE);
      end
    end else if (accept) begin
      unique case (reg_select)
        REG_MASK:   rd = mask_reg;
        REG_STATUS: rd = status_reg;
        REG_SPADDR: rd = sprite_addr_reg;
        REG_SPDATA: rd = sprite_data_reg;
        REG_SCROLL: rd = scroll_reg;
        REG_DATA: begin
          rd = buf_now;
          case (region)
            RGN_PATTERN: begin
              buf_load = 1'b1;
              buf_val  = chr_byte;
              took_chr = 1'b1;
            end
            RGN_NAME: begin
              name_req.re = 1'b1;
              set_pending = 1'b1;
            end
            RGN_PALETTE: begin
              buf_load = 1'b1;
              buf_val  = pal_q;
              rd       = pal_q;
            end
            default: begin
              buf_load = 1'b1;
              buf_val  = 8'h00;
            end
          endcase
        end
        default: rd = 8'h00;
      endcase
    end
  end

  // Next video address from register 6 writes
  always_comb begin
    video_address_next = video_address;
    if (accept && is_write && (reg_select == REG_ADDR)) begin
      if (high_byte_next) begin
        video_address_next = {write_data, video_address[7:0]};
      end else begin
        video_address_next = {video_address[15:8], write_data};
      end
    end
  end

  // Hold register file, address latch and read buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg     <= 8'h00;
      mask_reg        <= 8'h00;
      status_reg      <= 8'h00;
      sprite_addr_reg <= 8'h00;
      sprite_data_reg <= 8'h00;
      scroll_reg      <= 8'h00;
      video_address   <= 16'h0000;
      high_byte_next  <= 1'b0;
      read_buffer     <= 8'h00;
      buf_pending     <= 1'b0;
    end else begin
      video_address <= video_address_next;
      if (accept && is_write) begin
        unique case (reg_select)
          REG_CTRL:   control_reg     <= write_data;
          REG_MASK:   mask_reg        <= write_data;
          REG_STATUS: status_reg      <= write_data;
          REG_SPADDR: sprite_addr_reg <= write_data;
          REG_SPDATA: sprite_data_reg <= write_data;
          REG_SCROLL: scroll_reg      <= write_data;
          REG_ADDR:   high_byte_next  <= ~high_byte_next;
          default:    ;
        endcase
      end
      if (buf_load) begin
        read_buffer <= buf_val;
        buf_pending <= 1'b0;
      end else if (set_pending) begin
        buf_pending <= 1'b1;
      end
    end
  end

  // Advance or drop result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Capture result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data   <= rd;
      chr_address <= video_address_next[12:0];
      chr_read    <= took_chr;
    end
  end

  vrp_name_ram u_name_ram (
    .clk (clk),
    .req (name_req),
    .q   (ram_q)
  );

  vrp_palette u_palette (
    .clk     (clk),
    .rst     (rst),
    .req     (pal_req),
    .rd_data (pal_q)
  );

endmodule
